// ===== sv/rsti_pkg.sv =====
// rsti_pkg: shared types and constants for the radix string to integer unit.
// Used by rsti_front, rsti_back and the top level. No dependencies.
`timescale 1ns / 1ps

package rsti_pkg;

  // Converted value width default (top-level parameter default)
  localparam int VALUE_BITS_DEF = 64;

  // Configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;
  localparam int RADIX_W    = 6;

  localparam logic [CFG_IDX_W-1:0] REG_RADIX       = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE = CFG_IDX_W'(1);

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);

  // Result status codes
  localparam int STATUS_W = 2;
  localparam logic [STATUS_W-1:0] STATUS_OK      = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] STATUS_INVALID = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] STATUS_RANGE   = STATUS_W'(2);

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Character class decided by the front
  typedef enum logic [1:0] {
    KIND_SIGN,
    KIND_DIGIT,
    KIND_BAD
  } char_kind_e;

  // One classified character
  typedef struct packed {
    char_kind_e         kind;
    logic               neg;
    logic [RADIX_W-1:0] digit;
    logic               last;
  } char_entry_t;

  // Live configuration seen by front and back
  typedef struct packed {
    logic [RADIX_W-1:0] radix;
    logic               signed_mode;
  } cfg_t;

endpackage

// ===== sv/rsti_front.sv =====
// rsti_front: accepts characters, tracks the sign position and classifies
// each character as sign, digit or bad digit. Depends on rsti_pkg.
`timescale 1ns / 1ps

module rsti_front import rsti_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        accept_i,
  input  logic [7:0]  char_code_i,
  input  logic        last_char_i,
  output char_entry_t entry_o
);

  localparam logic [7:0] MINUS_CODE = 8'h2D;
  localparam logic [6:0] NO_DIGIT   = 7'd99;

  // ASCII digit or letter to its value, NO_DIGIT otherwise
  function automatic logic [6:0] digit_value(input logic [7:0] c);
    logic [6:0] v;
    v = NO_DIGIT;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 7'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      v = 7'(c - 8'h41) + 7'd10;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = 7'(c - 8'h61) + 7'd10;
    end
    return v;
  endfunction

  logic       awaiting_sign_q, awaiting_sign_d;
  logic [6:0] dval;

  // Next character after a last one is a sign
  always_comb begin
    awaiting_sign_d = awaiting_sign_q;
    if (accept_i) begin
      awaiting_sign_d = last_char_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_sign_q <= 1'b1;
    end else begin
      awaiting_sign_q <= awaiting_sign_d;
    end
  end

  // Classification
  assign dval = digit_value(char_code_i);

  always_comb begin
    entry_o.neg   = 1'b0;
    entry_o.digit = dval[RADIX_W-1:0];
    entry_o.last  = last_char_i;
    if (awaiting_sign_q) begin
      entry_o.kind  = KIND_SIGN;
      entry_o.neg   = (char_code_i == MINUS_CODE);
      entry_o.digit = '0;
    end else if (dval >= {1'b0, cfg_i.radix}) begin
      entry_o.kind = KIND_BAD;
    end else begin
      entry_o.kind = KIND_DIGIT;
    end
  end

endmodule

// ===== sv/rsti_queue.sv =====
// rsti_queue: small register FIFO that decouples front and back.
// Generic in width and depth; no package dependencies.
`timescale 1ns / 1ps

module rsti_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             valid_o,
  output logic             full_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == FULL_CNT);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = slot_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== sv/rsti_back.sv =====
// rsti_back: digit accumulation with exact overflow detection, result
// finishing (clamp, negate) and the output register. Depends on rsti_pkg.
`timescale 1ns / 1ps

module rsti_back import rsti_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  entry_valid_i,
  input  char_entry_t           entry_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [VALUE_BITS-1:0] value_bits_o,
  output logic [STATUS_W-1:0]   status_o
);

  localparam int PROD_W = VALUE_BITS + RADIX_W;
  localparam logic [VALUE_BITS-1:0] SMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic [VALUE_BITS-1:0] SMAX = ~SMIN;
  localparam logic [VALUE_BITS-1:0] UMAX = '1;

  typedef struct packed {
    logic [VALUE_BITS-1:0] acc;
    logic                  neg;
    logic                  ovf;
    logic                  bad;
    logic                  empty;
  } fin_t;

  logic [VALUE_BITS-1:0] acc_q, acc_d;
  logic                  neg_q, neg_d, ovf_q, ovf_d, bad_q, bad_d, empty_q, empty_d;
  logic [PROD_W-1:0]     prod;
  logic                  fin_valid_q, fin_valid_d;
  fin_t                  fin_q, fin_d;
  logic                  out_valid_q, out_valid_d;
  logic [VALUE_BITS-1:0] value_q, value_d;
  logic [STATUS_W-1:0]   status_q, status_d;
  logic                  out_ready, fin_ready, load_fin;

  // Handshake between stages
  assign out_ready = !out_valid_q || !out_stall_i;
  assign fin_ready = !fin_valid_q || out_ready;
  assign pop_o     = entry_valid_i && (!entry_i.last || fin_ready);
  assign load_fin  = pop_o && entry_i.last;

  // acc*radix+digit; any bit above the value width means overflow
  assign prod = PROD_W'(acc_q) * PROD_W'(cfg_i.radix) + PROD_W'(entry_i.digit);

  // Accumulator and string flags
  always_comb begin
    acc_d   = acc_q;
    neg_d   = neg_q;
    ovf_d   = ovf_q;
    bad_d   = bad_q;
    empty_d = empty_q;
    if (pop_o) begin
      case (entry_i.kind)
        KIND_SIGN: begin
          acc_d   = '0;
          neg_d   = entry_i.neg;
          ovf_d   = 1'b0;
          bad_d   = 1'b0;
          empty_d = 1'b1;
        end
        KIND_DIGIT: begin
          empty_d = 1'b0;
          if (!bad_q && !ovf_q) begin
            if (|prod[PROD_W-1:VALUE_BITS]) begin
              ovf_d = 1'b1;
            end else begin
              acc_d = prod[VALUE_BITS-1:0];
            end
          end
        end
        KIND_BAD: begin
          empty_d = 1'b0;
          bad_d   = 1'b1;
        end
        default: begin
          bad_d = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      neg_q   <= 1'b0;
      ovf_q   <= 1'b0;
      bad_q   <= 1'b0;
      empty_q <= 1'b0;
    end else begin
      acc_q   <= acc_d;
      neg_q   <= neg_d;
      ovf_q   <= ovf_d;
      bad_q   <= bad_d;
      empty_q <= empty_d;
    end
  end

  // Finish stage: capture the string's final state on its last character
  assign fin_d.acc   = acc_d;
  assign fin_d.neg   = neg_d;
  assign fin_d.ovf   = ovf_d;
  assign fin_d.bad   = bad_d;
  assign fin_d.empty = empty_d;

  always_comb begin
    fin_valid_d = fin_valid_q;
    if (load_fin) begin
      fin_valid_d = 1'b1;
    end else if (out_ready) begin
      fin_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
    end else begin
      fin_valid_q <= fin_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_fin) begin
      fin_q <= fin_d;
    end
  end

  // Result: empty/bad, then signed clamp, or unsigned saturate on overflow and wrap on negation
  always_comb begin
    value_d  = fin_q.acc;
    status_d = STATUS_OK;
    if (fin_q.empty || fin_q.bad) begin
      value_d  = '0;
      status_d = STATUS_INVALID;
    end else if (cfg_i.signed_mode) begin
      if (fin_q.neg) begin
        if (fin_q.ovf || fin_q.acc > SMIN) begin
          value_d  = SMIN;
          status_d = STATUS_RANGE;
        end else begin
          value_d = '0 - fin_q.acc;
        end
      end else if (fin_q.ovf || fin_q.acc > SMAX) begin
        value_d  = SMAX;
        status_d = STATUS_RANGE;
      end
    end else if (fin_q.ovf) begin
      value_d  = UMAX;
      status_d = STATUS_RANGE;
    end else if (fin_q.neg) begin
      value_d = '0 - fin_q.acc;
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready) begin
      out_valid_d = fin_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && fin_valid_q) begin
      value_q  <= value_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign value_bits_o = value_q;
  assign status_o     = status_q;

  // Checks on the back logic
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q == STATUS_INVALID |-> value_q == '0)
    else $error("invalid result with nonzero value");

  a_range_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q == STATUS_RANGE |->
      (value_q == UMAX || value_q == SMIN || value_q == SMAX))
    else $error("range result not saturated");

  a_empty_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_valid_q && fin_q.empty |-> !fin_q.ovf && !fin_q.bad)
    else $error("sign-only string carries digit flags");

  a_ovf_freezes_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q && pop_o && entry_i.kind == KIND_DIGIT |=> $stable(acc_q))
    else $error("accumulator moved after overflow");

  a_fin_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_valid_q && !out_ready |=> fin_valid_q && $stable(fin_q))
    else $error("finish stage lost a result under stall");

endmodule

// ===== sv/radix_string_to_integer_unit.sv =====
// radix_string_to_integer_unit: top level with configuration registers,
// front classifier, queue and back accumulator. Depends on rsti_pkg.
//
// Converts a character stream to integers, one character per clock cycle
// sustained unless the output stalls. The first character of each string is
// its sign ('-' negative); the rest are digits of the configured radix (2 to
// 36, letters either case). The front classifies a character in the cycle it
// is accepted and drops it into a two-entry queue; the back does one
// multiply-add with exact overflow check per cycle, so that single 64x6
// multiply-add sets the rate. After the last character is accepted, its
// result passes the queue, finish stage and output register; one result per
// string is given. Status is 0 ok, 1 empty or bad digit (value 0), 2 out of
// range (saturated value). Write radix (index 0) and signed_mode (index 1)
// only while the unit is idle; the config port is always ready.
`timescale 1ns / 1ps

module radix_string_to_integer_unit import rsti_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // character input
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            char_code_i,
  input  logic                  last_char_i,
  // result output
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [VALUE_BITS-1:0] value_bits_o,
  output logic [1:0]            status_o,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int ENTRY_W = $bits(char_entry_t);

  logic [RADIX_W-1:0] radix_q, radix_d;
  logic               signed_q, signed_d;
  cfg_t               cfg;
  logic               cfg_write, in_accept;
  char_entry_t        front_entry, back_entry;
  logic [ENTRY_W-1:0] queue_out;
  logic               queue_valid, queue_full, queue_pop;

  // Configuration registers
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_comb begin
    radix_d  = radix_q;
    signed_d = signed_q;
    if (cfg_write) begin
      if (cfg_index_i == REG_RADIX) begin
        radix_d = cfg_data_i[RADIX_W-1:0];
      end else if (cfg_index_i == REG_SIGNED_MODE) begin
        signed_d = cfg_data_i[0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q  <= RADIX_RESET;
      signed_q <= 1'b1;
    end else begin
      radix_q  <= radix_d;
      signed_q <= signed_d;
    end
  end

  // Out-of-range radix clamps to the nearest legal base
  always_comb begin
    cfg.radix = radix_q;
    if (radix_q < RADIX_MIN) begin
      cfg.radix = RADIX_MIN;
    end else if (radix_q > RADIX_MAX) begin
      cfg.radix = RADIX_MAX;
    end
    cfg.signed_mode = signed_q;
  end

  // Input transfer
  assign in_stall_o = queue_full;
  assign in_accept  = in_valid_i && !in_stall_o;

  rsti_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .accept_i    (in_accept),
    .char_code_i (char_code_i),
    .last_char_i (last_char_i),
    .entry_o     (front_entry)
  );

  rsti_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_accept),
    .data_i  (front_entry),
    .pop_i   (queue_pop),
    .data_o  (queue_out),
    .valid_o (queue_valid),
    .full_o  (queue_full)
  );

  assign back_entry = char_entry_t'(queue_out);

  rsti_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .entry_valid_i (queue_valid),
    .entry_i       (back_entry),
    .pop_o         (queue_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .value_bits_o  (value_bits_o),
    .status_o      (status_o)
  );

endmodule
